// ===== sv/utf8sd_pkg.sv =====
package utf8sd_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W = 31;
	localparam int STATUS_W = 2;
	localparam int PEND_W = 3;

	localparam logic [PEND_W-1:0] PEND_NONE = 3'd0;
	localparam logic [PEND_W-1:0] PEND_MAX = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_STRAY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd2;

	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_ASCII = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STRAY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MULTI = 2'd2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic end_of_text;
		logic [KIND_W-1:0] kind;
		logic [PEND_W-1:0] lead_pending;
		logic [CP_W-1:0] lead_value;
	} item_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic [STATUS_W-1:0] status;
		logic text_done;
	} result_t;

endpackage

// ===== sv/utf8sd_text_if.sv =====
interface utf8sd_text_if;
	logic valid;
	logic ready;
	logic [utf8sd_pkg::BYTE_W-1:0] text_byte;
	logic end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== sv/utf8sd_result_if.sv =====
interface utf8sd_result_if;
	logic valid;
	logic ready;
	logic [utf8sd_pkg::CP_W-1:0] code_point;
	logic [utf8sd_pkg::STATUS_W-1:0] status;
	logic text_done;

	modport source (output valid, output code_point, output status, output text_done,
		input ready);
	modport sink (input valid, input code_point, input status, input text_done,
		output ready);
endinterface

// ===== sv/utf8sd_front.sv =====
module utf8sd_front (
	input  logic clk,
	input  logic arst_n,
	utf8sd_text_if.sink text,
	output logic push,
	output utf8sd_pkg::item_t push_item,
	input  logic queue_full
);

	localparam logic [7:0] LEAD1_LIMIT = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF0;
	localparam logic [7:0] LEAD5_MASK = 8'hF8;
	localparam logic [7:0] LEAD6_MASK = 8'hFC;

	utf8sd_pkg::item_t cls;
	utf8sd_pkg::item_t item_s1;
	logic valid_s1;
	logic load;
	logic [7:0] b;

	assign b = text.text_byte;

	always_comb begin
		cls.text_byte = b;
		cls.end_of_text = text.end_of_text;
		cls.kind = utf8sd_pkg::KIND_MULTI;
		cls.lead_pending = utf8sd_pkg::PEND_NONE;
		cls.lead_value = '0;
		if ((b & LEAD6_MASK) == LEAD6_MASK) begin
			cls.lead_pending = 3'd5;
			cls.lead_value = {b[0], 30'd0};
		end else if ((b & LEAD5_MASK) == LEAD5_MASK) begin
			cls.lead_pending = 3'd4;
			cls.lead_value = utf8sd_pkg::CP_W'({b[1:0], 24'd0});
		end else if ((b & LEAD4_MASK) == LEAD4_MASK) begin
			cls.lead_pending = 3'd3;
			cls.lead_value = utf8sd_pkg::CP_W'({b[2:0], 18'd0});
		end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
			cls.lead_pending = 3'd2;
			cls.lead_value = utf8sd_pkg::CP_W'({b[3:0], 12'd0});
		end else if ((b & LEAD2_MASK) == LEAD2_MASK) begin
			cls.lead_pending = 3'd1;
			cls.lead_value = utf8sd_pkg::CP_W'({b[4:0], 6'd0});
		end else if (b < LEAD1_LIMIT) begin
			cls.kind = utf8sd_pkg::KIND_ASCII;
		end else begin
			cls.kind = utf8sd_pkg::KIND_STRAY;
		end
	end

	assign push = valid_s1 && !queue_full;
	assign text.ready = !valid_s1 || !queue_full;
	assign load = text.valid && text.ready;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= cls;
		end
	end

endmodule

// ===== sv/utf8sd_queue.sv =====
module utf8sd_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  utf8sd_pkg::item_t push_item,
	output logic full,
	input  logic pop,
	output utf8sd_pkg::item_t pop_item,
	output logic not_empty
);

	utf8sd_pkg::item_t mem [utf8sd_pkg::QUEUE_DEPTH];
	logic [utf8sd_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [utf8sd_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [utf8sd_pkg::QUEUE_CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == utf8sd_pkg::QUEUE_CW'(utf8sd_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign pop_item = mem[rd_ptr_q];

	function automatic logic [utf8sd_pkg::QUEUE_AW-1:0] next_ptr(
		input logic [utf8sd_pkg::QUEUE_AW-1:0] p
	);
		if (p == utf8sd_pkg::QUEUE_AW'(utf8sd_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= utf8sd_pkg::QUEUE_CW'(utf8sd_pkg::QUEUE_DEPTH))
		else $error("queue count exceeds depth");

endmodule

// ===== sv/utf8sd_back.sv =====
module utf8sd_back (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  utf8sd_pkg::item_t item,
	output logic take,
	utf8sd_result_if.source result
);

	logic [utf8sd_pkg::PEND_W-1:0] pending_q;
	logic [utf8sd_pkg::CP_W-1:0] partial_q;
	logic out_valid_q;
	utf8sd_pkg::result_t out_q;

	logic [utf8sd_pkg::PEND_W-1:0] pending_d;
	logic [utf8sd_pkg::CP_W-1:0] partial_d;
	logic emit;
	utf8sd_pkg::result_t res_d;
	logic [4:0] shift;
	logic [utf8sd_pkg::PEND_W-1:0] pend_dec;
	logic [utf8sd_pkg::CP_W-1:0] merged;

	assign take = item_valid && (!out_valid_q || result.ready);
	assign pend_dec = pending_q - 1'b1;

	always_comb begin
		unique case (pending_q)
			3'd1: shift = 5'd0;
			3'd2: shift = 5'd6;
			3'd3: shift = 5'd12;
			3'd4: shift = 5'd18;
			default: shift = 5'd24;
		endcase
	end

	assign merged = partial_q | (utf8sd_pkg::CP_W'(item.text_byte[5:0]) << shift);

	always_comb begin
		pending_d = pending_q;
		partial_d = partial_q;
		emit = 1'b0;
		res_d.code_point = '0;
		res_d.status = utf8sd_pkg::ST_OK;
		res_d.text_done = item.end_of_text;
		if (pending_q == utf8sd_pkg::PEND_NONE) begin
			unique case (item.kind)
				utf8sd_pkg::KIND_ASCII: begin
					emit = 1'b1;
					partial_d = '0;
					res_d.code_point = utf8sd_pkg::CP_W'(item.text_byte);
				end
				utf8sd_pkg::KIND_STRAY: begin
					emit = 1'b1;
					partial_d = '0;
					res_d.status = utf8sd_pkg::ST_STRAY;
				end
				default: begin
					pending_d = item.lead_pending;
					partial_d = item.lead_value;
				end
			endcase
		end else begin
			pending_d = pend_dec;
			if (pend_dec == utf8sd_pkg::PEND_NONE) begin
				emit = 1'b1;
				partial_d = '0;
				res_d.code_point = merged;
			end else begin
				partial_d = merged;
			end
		end
		if (!emit && item.end_of_text) begin
			emit = 1'b1;
			pending_d = utf8sd_pkg::PEND_NONE;
			partial_d = '0;
			res_d.code_point = '0;
			res_d.status = utf8sd_pkg::ST_TRUNCATED;
			res_d.text_done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= utf8sd_pkg::PEND_NONE;
			partial_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				pending_q <= pending_d;
				partial_q <= partial_d;
				out_valid_q <= emit;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_q <= res_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.code_point = out_q.code_point;
	assign result.status = out_q.status;
	assign result.text_done = out_q.text_done;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != utf8sd_pkg::ST_OK |-> out_q.code_point == '0)
		else $error("error result carries a nonzero code point");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == utf8sd_pkg::ST_TRUNCATED |-> out_q.text_done)
		else $error("truncated result without end of text");

	assert property (@(posedge clk) disable iff (!arst_n)
		take && item.end_of_text |=> pending_q == utf8sd_pkg::PEND_NONE)
		else $error("decoder state not idle after end of text");

	assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= utf8sd_pkg::PEND_MAX)
		else $error("pending byte count out of range");

endmodule

// ===== sv/utf8_stream_decoder.sv =====
// Decodes UTF-8 text, one byte per beat on the text channel, into code points on
// the result channel, following the original scheme of one to six bytes per
// sequence (0xFE and 0xFF act as six-byte leads, overlong forms pass, and the top
// two bits of following bytes are ignored). A result beat is given when a sequence
// completes (status 0), when a continuation byte shows up in lead position
// (status 1, code point 0), or when end_of_text arrives inside a sequence
// (status 2, code point 0, text_done 1); after the last byte the decoder is idle.
// The block sustains one byte per cycle while the result channel is ready. A byte
// passes through the classifying input register and then the two-entry queue
// ahead of the decode stage, whose output register holds the result until it is
// taken.
module utf8_stream_decoder (
	input logic clk,
	input logic arst_n,
	utf8sd_text_if.sink text,
	utf8sd_result_if.source result
);

	logic push;
	utf8sd_pkg::item_t push_item;
	logic queue_full;
	logic pop;
	utf8sd_pkg::item_t pop_item;
	logic not_empty;

	utf8sd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.text(text),
		.push(push),
		.push_item(push_item),
		.queue_full(queue_full)
	);

	utf8sd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(queue_full),
		.pop(pop),
		.pop_item(pop_item),
		.not_empty(not_empty)
	);

	utf8sd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(not_empty),
		.item(pop_item),
		.take(pop),
		.result(result)
	);

endmodule

// ===== tb/utf8_stream_decoder_tb.sv =====
module utf8_stream_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [utf8sd_pkg::BYTE_W-1:0] LEAD6_MASK = 8'hFC;
	localparam logic [utf8sd_pkg::BYTE_W-1:0] LEAD5_MASK = 8'hF8;
	localparam logic [utf8sd_pkg::BYTE_W-1:0] LEAD4_MASK = 8'hF0;
	localparam logic [utf8sd_pkg::BYTE_W-1:0] LEAD3_MASK = 8'hE0;
	localparam logic [utf8sd_pkg::BYTE_W-1:0] LEAD2_MASK = 8'hC0;
	localparam logic [utf8sd_pkg::BYTE_W-1:0] ASCII_LIMIT = 8'h80;
	localparam logic [utf8sd_pkg::BYTE_W-1:0] CONT_MARK = 8'h80;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 20;

	logic clk;
	logic arst_n;

	utf8sd_text_if text_ch();
	utf8sd_result_if result_ch();

	utf8_stream_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.result(result_ch)
	);

	logic [utf8sd_pkg::PEND_W-1:0] dec_pending;
	logic [utf8sd_pkg::CP_W-1:0] dec_partial;
	utf8sd_pkg::result_t expected_results[$];

	int send_idle_pct;
	int recv_stall_pct;
	int bytes_sent;
	int results_checked;
	int fail_count;
	int cycle_count;
	int status_seen[3];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic bit decode_byte(input logic [utf8sd_pkg::BYTE_W-1:0] b,
		input logic eot, output utf8sd_pkg::result_t res);
		int shift;
		res = '0;
		if (dec_pending == utf8sd_pkg::PEND_NONE) begin
			if ((b & LEAD6_MASK) == LEAD6_MASK) begin
				dec_partial = utf8sd_pkg::CP_W'(b[0]) << 30;
				dec_pending = 3'd5;
			end else if ((b & LEAD5_MASK) == LEAD5_MASK) begin
				dec_partial = utf8sd_pkg::CP_W'(b[1:0]) << 24;
				dec_pending = 3'd4;
			end else if ((b & LEAD4_MASK) == LEAD4_MASK) begin
				dec_partial = utf8sd_pkg::CP_W'(b[2:0]) << 18;
				dec_pending = 3'd3;
			end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
				dec_partial = utf8sd_pkg::CP_W'(b[3:0]) << 12;
				dec_pending = 3'd2;
			end else if ((b & LEAD2_MASK) == LEAD2_MASK) begin
				dec_partial = utf8sd_pkg::CP_W'(b[4:0]) << 6;
				dec_pending = 3'd1;
			end else if (b < ASCII_LIMIT) begin
				dec_partial = '0;
				res.code_point = utf8sd_pkg::CP_W'(b);
				res.status = utf8sd_pkg::ST_OK;
				res.text_done = eot;
				return 1'b1;
			end else begin
				dec_partial = '0;
				res.status = utf8sd_pkg::ST_STRAY;
				res.text_done = eot;
				return 1'b1;
			end
		end else begin
			shift = 6 * (int'(dec_pending) - 1);
			if (shift > 24)
				shift = 24;
			dec_partial = dec_partial | (utf8sd_pkg::CP_W'(b[5:0]) << shift);
			dec_pending = dec_pending - 3'd1;
			if (dec_pending == utf8sd_pkg::PEND_NONE) begin
				res.code_point = dec_partial;
				res.status = utf8sd_pkg::ST_OK;
				res.text_done = eot;
				dec_partial = '0;
				return 1'b1;
			end
		end
		if (eot) begin
			dec_pending = utf8sd_pkg::PEND_NONE;
			dec_partial = '0;
			res.status = utf8sd_pkg::ST_TRUNCATED;
			res.text_done = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		utf8sd_pkg::result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_checked <= results_checked + 1;
			if (expected_results.size() == 0) begin
				$error("Result beat with nothing expected: code_point %h status %0d",
					result_ch.code_point, result_ch.status);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (want.status <= utf8sd_pkg::ST_TRUNCATED)
					status_seen[want.status] <= status_seen[want.status] + 1;
				if (result_ch.code_point !== want.code_point) begin
					$error("code_point expected %h actual %h", want.code_point,
						result_ch.code_point);
					fail_count++;
				end
				if (result_ch.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, result_ch.status);
					fail_count++;
				end
				if (result_ch.text_done !== want.text_done) begin
					$error("text_done expected %0d actual %0d", want.text_done,
						result_ch.text_done);
					fail_count++;
				end
			end
		end
	end

	task automatic send_byte(input logic [utf8sd_pkg::BYTE_W-1:0] b, input logic eot);
		utf8sd_pkg::result_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			text_ch.valid <= 1'b0;
			@(negedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.end_of_text <= eot;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		bytes_sent++;
		if (decode_byte(b, eot, res))
			expected_results.insert(expected_results.size(), res);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		text_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_single_byte_forms();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hBF, 1'b1);
		send_byte(8'h41, 1'b1);
	endtask

	task automatic test_multibyte_extremes();
		send_byte(8'hDF, 1'b0);
		send_byte(8'h3F, 1'b0);
		send_byte(8'hE0, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hF7, 1'b0);
		repeat (3) send_byte(8'hBF, 1'b0);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hC0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFF, 1'b0);
		repeat (4) send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b1);
	endtask

	task automatic test_truncated_text();
		send_byte(8'hFE, 1'b1);
		send_byte(8'hE5, 1'b0);
		send_byte(8'h80, 1'b1);
		send_byte(8'hFC, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h81, 1'b1);
	endtask

	task automatic send_random_sequence();
		int pick;
		int len;
		int cut;
		logic [utf8sd_pkg::BYTE_W-1:0] b;
		logic eot;
		pick = $urandom_range(99);
		if (pick < 10) begin
			send_byte(utf8sd_pkg::BYTE_W'($urandom), ($urandom_range(15) == 0));
			return;
		end
		len = $urandom_range(1, 6);
		cut = (pick < 22) ? $urandom_range(1, len) : 0;
		for (int i = 1; i <= len; i++) begin
			if (i == 1) begin
				case (len)
					1: b = utf8sd_pkg::BYTE_W'($urandom_range(0, 127));
					2: b = 8'hC0 | utf8sd_pkg::BYTE_W'($urandom_range(0, 31));
					3: b = 8'hE0 | utf8sd_pkg::BYTE_W'($urandom_range(0, 15));
					4: b = 8'hF0 | utf8sd_pkg::BYTE_W'($urandom_range(0, 7));
					5: b = 8'hF8 | utf8sd_pkg::BYTE_W'($urandom_range(0, 3));
					default: b = 8'hFC | utf8sd_pkg::BYTE_W'($urandom_range(0, 3));
				endcase
			end else if ($urandom_range(7) == 0) begin
				b = utf8sd_pkg::BYTE_W'($urandom);
			end else begin
				b = CONT_MARK | utf8sd_pkg::BYTE_W'($urandom_range(0, 63));
			end
			eot = (i == cut) || (i == len && cut == 0 && $urandom_range(15) == 0);
			send_byte(b, eot);
			if (i == cut)
				break;
		end
	endtask

	task automatic test_random_text(input int n_bytes, input int idle_pct, input int stall_pct);
		int target;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			send_random_sequence();
			if ($urandom_range(199) == 0)
				wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = '0;
		text_ch.end_of_text = 1'b0;
		result_ch.ready = 1'b0;
		dec_pending = utf8sd_pkg::PEND_NONE;
		dec_partial = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		bytes_sent = 0;
		results_checked = 0;
		fail_count = 0;
		cycle_count = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_single_byte_forms();
		test_multibyte_extremes();
		test_truncated_text();
		wait_drained();
		test_random_text(440, 0, 0);
		wait_drained();
		test_random_text(440, 71, 0);
		test_random_text(440, 0, 71);
		test_random_text(440, 9, 9);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d text bytes under four idling patterns; checked %0d results",
			bytes_sent, results_checked);
		$display("Results by status: %0d ok, %0d stray byte, %0d truncated text",
			status_seen[utf8sd_pkg::ST_OK], status_seen[utf8sd_pkg::ST_STRAY],
			status_seen[utf8sd_pkg::ST_TRUNCATED]);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
